// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property checked at every rising edge, off while reset is high
`define ASSERT_AT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same-cycle implication, off while reset is high
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rst, prop, msg)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ----- rtl/sprc_pkg.sv -----
// ----------------------------------------------------------------------------
// sprc_pkg
// Types and constants of the sprite record to tile column decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sprc_pkg;

  // tile edge in pixels and fixed horizontal offset
  localparam int TILE_PIXELS = 16;
  localparam int X_OFFSET    = 32;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 10;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SCREEN_FLIPPED = 2'd0,
    REG_SCREEN_WIDTH   = 2'd1,
    REG_SCREEN_HEIGHT  = 2'd2
  } cfg_reg_t;

  localparam logic [9:0] SCREEN_WIDTH_RESET  = 10'd320;
  localparam logic [9:0] SCREEN_HEIGHT_RESET = 10'd224;

  typedef struct packed {
    logic       screen_flipped;
    logic [9:0] screen_width;
    logic [9:0] screen_height;
  } cfg_t;

  // one sprite record
  typedef struct packed {
    logic [15:0] attr_word;
    logic [15:0] size_word;
    logic [15:0] code_word;
    logic [15:0] x_word;
    logic [15:0] y_word;
    logic [15:0] color_word;
  } sprite_t;

  // one column drawing command
  typedef struct packed {
    logic [15:0]        column_code;
    logic signed [11:0] column_x;
    logic signed [11:0] column_y;
    logic [4:0]         tile_count;
    logic               code_descends;
    logic               mirror_x;
    logic               mirror_y;
    logic [5:0]         palette;
    logic               last_column;
  } column_t;

  // decoded sprite, as queued for the column walker
  typedef struct packed {
    logic [15:0]        code;
    logic signed [11:0] x;
    logic signed [11:0] y;
    logic [4:0]         rows;
    logic [3:0]         cols_m1;
    logic               descend;
    logic               mx;
    logic               my;
    logic [5:0]         pal;
  } cmd_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// ----- rtl/sprc_front.sv -----
// ----------------------------------------------------------------------------
// sprc_front
// Classifies a sprite record and decodes it into one column-walk command.
// ----------------------------------------------------------------------------
`default_nettype none

module sprc_front (
  input  wire sprc_pkg::sprite_t sprite,
  input  wire logic              push,
  input  wire sprc_pkg::cfg_t    cfg,
  input  wire sprc_pkg::q_stat_t q_stat,
  output logic                   full,
  output logic                   q_push,
  output sprc_pkg::cmd_t         cmd
);

  logic [4:0]  cols;
  logic [4:0]  rows;
  logic [8:0]  area;
  logic [15:0] code_flip;
  logic [15:0] code_sel;
  logic [11:0] sx;
  logic [11:0] sy;
  logic [11:0] cols_px;
  logic [11:0] rows_px;

  assign full = q_stat.full;

  // disabled sprites are taken and dropped
  assign q_push = push && !q_stat.full && sprite.attr_word[0];

  // sprite geometry
  always_comb begin
    cols      = {1'b0, sprite.size_word[3:0]} + 5'd1;
    rows      = {1'b0, sprite.size_word[7:4]} + 5'd1;
    area      = {4'd0, cols} * {4'd0, rows};
    cols_px   = 12'(cols * sprc_pkg::TILE_PIXELS);
    rows_px   = 12'(rows * sprc_pkg::TILE_PIXELS);
    sx        = {{2{sprite.x_word[9]}}, sprite.x_word[9:0]};
    sy        = {{2{sprite.y_word[9]}}, sprite.y_word[9:0]};
    code_flip = sprite.code_word + {7'd0, area} - 16'd1;
    code_sel  = cfg.screen_flipped ? code_flip : sprite.code_word;
  end

  // command fields, mirrored against the screen when flipped
  always_comb begin
    cmd.code    = {sprite.size_word[8], code_sel[14:0]};
    cmd.rows    = rows;
    cmd.cols_m1 = sprite.size_word[3:0];
    cmd.descend = cfg.screen_flipped;
    cmd.mx      = sprite.size_word[12] ^ cfg.screen_flipped;
    cmd.my      = cfg.screen_flipped;
    cmd.pal     = sprite.color_word[5:0];
    if (cfg.screen_flipped) begin
      cmd.x = $signed({2'b00, cfg.screen_width} - sx - cols_px - 12'(sprc_pkg::X_OFFSET));
      cmd.y = $signed({2'b00, cfg.screen_height} - sy - rows_px);
    end else begin
      cmd.x = $signed(sx + 12'(sprc_pkg::X_OFFSET));
      cmd.y = $signed(sy);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sprc_queue.sv -----
// ----------------------------------------------------------------------------
// sprc_queue
// Short command queue that decouples the decoder from the column walker.
// ----------------------------------------------------------------------------
`default_nettype none

module sprc_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_push,
  input  wire sprc_pkg::cmd_t    q_wdata,
  input  wire logic              q_pop,
  output sprc_pkg::cmd_t         q_rdata,
  output sprc_pkg::q_stat_t      q_stat
);

  localparam int                        DEPTH = sprc_pkg::QUEUE_DEPTH;
  localparam logic [sprc_pkg::QPTR_W-1:0] LAST_PTR = sprc_pkg::QPTR_W'(DEPTH - 1);

  sprc_pkg::cmd_t                entries [DEPTH];
  logic [sprc_pkg::QPTR_W-1:0]   wr_ptr;
  logic [sprc_pkg::QPTR_W-1:0]   rd_ptr;
  logic [sprc_pkg::QCNT_W-1:0]   count;
  logic                          do_push;
  logic                          do_pop;

  assign q_stat.full  = (count == sprc_pkg::QCNT_W'(DEPTH));
  assign q_stat.empty = (count == '0);
  assign do_push      = q_push && !q_stat.full;
  assign do_pop       = q_pop && !q_stat.empty;
  assign q_rdata      = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= q_wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sprc_back.sv -----
// ----------------------------------------------------------------------------
// sprc_back
// Walks a queued command's columns, one column per cycle unless pop stalls it.
// ----------------------------------------------------------------------------
`default_nettype none

module sprc_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sprc_pkg::cmd_t    q_rdata,
  input  wire sprc_pkg::q_stat_t q_stat,
  output logic                   q_pop,
  input  wire logic              pop,
  output logic                   empty,
  output sprc_pkg::column_t      column
);

  logic               busy;
  logic               out_valid;
  logic               advance;
  logic               last;
  logic [3:0]         col_idx;
  sprc_pkg::cmd_t     cur;

  assign empty   = !out_valid;
  assign q_pop   = !busy && !q_stat.empty;
  assign advance = busy && (!out_valid || pop);
  assign last    = (col_idx == cur.cols_m1);

  // control: command load and output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
      end else if (advance && last) begin
        busy <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working command: code and x step per column
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur     <= q_rdata;
      col_idx <= '0;
    end else if (advance) begin
      cur.code <= cur.descend ? cur.code - {11'd0, cur.rows}
                              : cur.code + {11'd0, cur.rows};
      cur.x    <= cur.x + 12'(sprc_pkg::TILE_PIXELS);
      col_idx  <= col_idx + 4'd1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (advance) begin
      column.column_code   <= cur.code;
      column.column_x      <= cur.x;
      column.column_y      <= cur.y;
      column.tile_count    <= cur.rows;
      column.code_descends <= cur.descend;
      column.mirror_x      <= cur.mx;
      column.mirror_y      <= cur.my;
      column.palette       <= cur.pal;
      column.last_column   <= last;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sprite_record_to_tile_columns_top.sv -----
// ----------------------------------------------------------------------------
// sprite_record_to_tile_columns_top
// Sprite attribute record in, one tile column command per column out.
// ----------------------------------------------------------------------------
// A record is taken whenever full is low. A disabled record is
// dropped at once; an enabled one is decoded and waits in a two-entry command
// queue. The column walker then loads the command and steps through its
// columns, so an enabled record of N columns (1 to 16) gives N column
// commands; the walker takes the next command only after the last column.
// Results sit in an output register, so a stalled pop holds the walker but
// the queue keeps taking records until it is full. Screen registers are
// meant to be written only while the block is idle.
`default_nettype none

`include "assert_macros.svh"

module sprite_record_to_tile_columns_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [sprc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [sprc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                push,
  output logic                                     full,
  input  wire sprc_pkg::sprite_t                   sprite,
  output logic                                     empty,
  input  wire logic                                pop,
  output sprc_pkg::column_t                        column
);

  sprc_pkg::cfg_t    cfg;
  sprc_pkg::q_stat_t q_stat;
  sprc_pkg::cmd_t    q_wdata;
  sprc_pkg::cmd_t    q_rdata;
  logic              q_push;
  logic              q_pop;

  // screen registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_flipped <= 1'b0;
      cfg.screen_width   <= sprc_pkg::SCREEN_WIDTH_RESET;
      cfg.screen_height  <= sprc_pkg::SCREEN_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        sprc_pkg::REG_SCREEN_FLIPPED: cfg.screen_flipped <= cfg_data[0];
        sprc_pkg::REG_SCREEN_WIDTH:   cfg.screen_width   <= cfg_data[9:0];
        sprc_pkg::REG_SCREEN_HEIGHT:  cfg.screen_height  <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  // record decoder
  sprc_front u_front (
    .sprite (sprite),
    .push   (push),
    .cfg    (cfg),
    .q_stat (q_stat),
    .full   (full),
    .q_push (q_push),
    .cmd    (q_wdata)
  );

  // command queue
  sprc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_pop   (q_pop),
    .q_rdata (q_rdata),
    .q_stat  (q_stat)
  );

  // column walker
  sprc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_rdata (q_rdata),
    .q_stat  (q_stat),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .column  (column)
  );

  // checks
  `ASSERT_IMPLIES(a_pop_nonempty, clk, rst, q_pop, !q_stat.empty, "walker popped empty queue")
  `ASSERT_AT(a_enabled_queued, clk, rst, push && !full && sprite.attr_word[0] |=> !q_stat.empty, "enabled record not queued")
  `ASSERT_IMPLIES(a_rows_nonzero, clk, rst, !empty, column.tile_count != 5'd0, "column with no tiles")
  `ASSERT_IMPLIES(a_flip_consistent, clk, rst, !empty, column.mirror_y == column.code_descends, "flip flags disagree")

endmodule

`default_nettype wire

// ----- verif/sprite_columns_checker.sv -----
// ----------------------------------------------------------------------------
// sprite_columns_checker
// Watches the record, column and register ports of the sprite column decoder,
// works out the column commands each accepted record should produce and
// compares every delivered column against the oldest one still outstanding.
// ----------------------------------------------------------------------------
module sprite_columns_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [sprc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sprc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                push,
  input  logic                                full,
  input  sprc_pkg::sprite_t                   sprite,
  input  logic                                empty,
  input  logic                                pop,
  input  sprc_pkg::column_t                   column,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  columns_checked
);

  import sprc_pkg::*;

  // local copy of the screen registers
  logic       flip_cfg;
  logic [9:0] width_cfg;
  logic [9:0] height_cfg;

  // column commands still owed by the block, oldest first
  column_t expected_columns[$];

  // one field compare, reported on its own
  function void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // expand one enabled record into its column commands
  function void decode_record(input sprite_t rec);
    int          cols;
    int          rows;
    int          sx;
    int          sy;
    int          cx;
    int          code_sum;
    logic [15:0] code;
    logic [15:0] step;
    logic        mx;
    logic        my;
    column_t     col;
    cols = int'(rec.size_word[3:0]) + 1;
    rows = int'(rec.size_word[7:4]) + 1;
    sx = int'($signed(rec.x_word[9:0]));
    sy = int'($signed(rec.y_word[9:0]));
    mx = rec.size_word[12];
    my = 1'b0;
    code = rec.code_word;
    if (flip_cfg) begin
      // mirror against the screen, start from the last tile and walk down
      sx = int'(width_cfg) - sx - cols * TILE_PIXELS - X_OFFSET;
      sy = int'(height_cfg) - sy - rows * TILE_PIXELS;
      mx = ~mx;
      my = 1'b1;
      code_sum = int'(rec.code_word) + cols * rows - 1;
      code = code_sum[15:0];
      step = 16'd0 - rows[15:0];
    end else begin
      sx = sx + X_OFFSET;
      step = rows[15:0];
    end
    // carry out of bit 14 is dropped, bit 15 comes from the size word
    code = {rec.size_word[8], code[14:0]};
    for (int c = 0; c < cols; c++) begin
      cx = sx + c * TILE_PIXELS;
      col.column_code   = code;
      col.column_x      = cx[11:0];
      col.column_y      = sy[11:0];
      col.tile_count    = rows[4:0];
      col.code_descends = flip_cfg;
      col.mirror_x      = mx;
      col.mirror_y      = my;
      col.palette       = rec.color_word[5:0];
      col.last_column   = (c == cols - 1);
      expected_columns.push_back(col);
      code = code + step;
    end
  endfunction

  always @(posedge clk) begin
    column_t want;
    if (rst) begin
      flip_cfg = 1'b0;
      width_cfg = SCREEN_WIDTH_RESET;
      height_cfg = SCREEN_HEIGHT_RESET;
      expected_columns.delete();
      fail_count = 0;
      columns_checked = 0;
    end else begin
      // column transfer against the oldest outstanding command
      if (pop && !empty) begin
        if (expected_columns.size() == 0) begin
          $error("column transfer with nothing outstanding: code %0h", column.column_code);
          fail_count++;
        end else begin
          want = expected_columns.pop_front();
          check_field("column_code", int'(want.column_code), int'(column.column_code));
          check_field("column_x", int'(want.column_x), int'(column.column_x));
          check_field("column_y", int'(want.column_y), int'(column.column_y));
          check_field("tile_count", int'(want.tile_count), int'(column.tile_count));
          check_field("code_descends", int'(want.code_descends),
                      int'(column.code_descends));
          check_field("mirror_x", int'(want.mirror_x), int'(column.mirror_x));
          check_field("mirror_y", int'(want.mirror_y), int'(column.mirror_y));
          check_field("palette", int'(want.palette), int'(column.palette));
          check_field("last_column", int'(want.last_column), int'(column.last_column));
          columns_checked++;
        end
      end
      // record transfer, disabled records give nothing
      if (push && !full && sprite.attr_word[0])
        decode_record(sprite);
      // register writes
      if (cfg_write) begin
        case (cfg_index)
          REG_SCREEN_FLIPPED: flip_cfg = cfg_data[0];
          REG_SCREEN_WIDTH:   width_cfg = cfg_data;
          REG_SCREEN_HEIGHT:  height_cfg = cfg_data;
          default: ;
        endcase
      end
    end
    pending = expected_columns.size();
  end

endmodule

// ----- verif/sprite_record_to_tile_columns_top_tb.sv -----
// ----------------------------------------------------------------------------
// sprite_record_to_tile_columns_top_tb
// Drives sprite records and screen settings into the column decoder: a short
// directed set of edge cases, then random records under changing settings
// and idle patterns, including a long output stall that backs up the input.
// Checking is done by sprite_columns_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module sprite_record_to_tile_columns_top_tb;

  import sprc_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 24;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_RECORDS  = 20;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_SCREEN_FLIPPED;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   push = 1'b0;
  logic                   full;
  sprite_t                sprite = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  column_t                column;

  int fail_count;
  int pending;
  int columns_checked;
  int records_sent = 0;
  int enabled_sent = 0;
  int settings_used = 1;
  int send_idle_pct = 24;
  int take_idle_pct = 78;
  int idle_cycles = 0;
  bit holdoff_req = 1'b0;
  bit holdoff_taken = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sprite_record_to_tile_columns_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .sprite    (sprite),
    .empty     (empty),
    .pop       (pop),
    .column    (column)
  );

  sprite_columns_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .push            (push),
    .full            (full),
    .sprite          (sprite),
    .empty           (empty),
    .pop             (pop),
    .column          (column),
    .fail_count      (fail_count),
    .pending         (pending),
    .columns_checked (columns_checked)
  );

  // give up when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // column side: random pop, with one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (holdoff_req && !holdoff_taken) begin
        holdoff_taken = 1'b1;
        pop <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
      end
      pop <= ($urandom_range(99) >= take_idle_pct);
    end
  end

  function automatic sprite_t sprite_of(input logic [15:0] attr, input logic [15:0] size,
                                        input logic [15:0] code, input logic [15:0] xw,
                                        input logic [15:0] yw, input logic [15:0] color);
    sprite_t s;
    s.attr_word = attr;
    s.size_word = size;
    s.code_word = code;
    s.x_word = xw;
    s.y_word = yw;
    s.color_word = color;
    return s;
  endfunction

  // random record, mostly enabled and mostly narrow
  function automatic sprite_t random_sprite();
    sprite_t s;
    s = sprite_of(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
    s.attr_word[0] = ($urandom_range(7) != 0);
    if ($urandom_range(3) != 0)
      s.size_word[3:0] = 4'($urandom_range(3));
    if ($urandom_range(3) == 0)
      s.x_word[9:0] = $urandom_range(1) ? 10'h1ff : 10'h200;
    if ($urandom_range(3) == 0)
      s.y_word[9:0] = $urandom_range(1) ? 10'h1ff : 10'h200;
    return s;
  endfunction

  // one record transfer, called and returning at a falling edge
  task automatic send_record(input sprite_t rec);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    sprite <= rec;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    records_sent++;
    if (rec.attr_word[0])
      enabled_sent++;
  endtask

  // stop offering and wait until every column has come out
  task automatic end_phase();
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // write all three screen registers, block idle
  task automatic write_config(input logic flip, input logic [9:0] width,
                              input logic [9:0] height);
    logic [9:0] junk;
    junk = 10'($urandom);
    cfg_write <= 1'b1;
    cfg_index <= REG_SCREEN_FLIPPED;
    cfg_data <= {junk[9:1], flip};
    @(negedge clk);
    cfg_index <= REG_SCREEN_WIDTH;
    cfg_data <= width;
    @(negedge clk);
    cfg_index <= REG_SCREEN_HEIGHT;
    cfg_data <= height;
    @(negedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int enabled_target;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: disabled records, field extremes, code wrap, unused bits
    send_record(sprite_of(16'hfffe, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_record(sprite_of(16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_record(sprite_of(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_record(sprite_of(16'h0001, 16'h000f, 16'h1234, 16'h01ff, 16'h0200, 16'h003f));
    send_record(sprite_of(16'h0001, 16'h00f0, 16'h0000, 16'h0200, 16'h01ff, 16'h0000));
    send_record(sprite_of(16'h0001, 16'h0111, 16'h7fff, 16'h03ff, 16'h0000, 16'hffc0));
    send_record(sprite_of(16'hffff, 16'hee00, 16'h8000, 16'hfc00, 16'hfc00, 16'hffc0));
    send_record(sprite_of(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    end_phase();

    // flipped, largest screen: descending codes, lost carry, wrap below zero
    write_config(1'b1, 10'd1023, 10'd1023);
    send_record(sprite_of(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_record(sprite_of(16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_record(sprite_of(16'h0001, 16'h00ff, 16'h7ff0, 16'h01ff, 16'h0200, 16'h0015));
    send_record(sprite_of(16'h0001, 16'h10ff, 16'h7fff, 16'h0200, 16'h01ff, 16'h002a));
    send_record(sprite_of(16'h0001, 16'h0111, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_record(sprite_of(16'hfffe, 16'h0111, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    end_phase();

    // flipped against a zero-sized screen
    write_config(1'b1, 10'd0, 10'd0);
    send_record(sprite_of(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_record(sprite_of(16'h0001, 16'h0105, 16'h4000, 16'h01ff, 16'h01ff, 16'h0001));
    end_phase();

    // flipped against the smallest legal screen
    write_config(1'b1, 10'd1, 10'd1);
    send_record(sprite_of(16'h0001, 16'h0f0f, 16'h1111, 16'h0200, 16'h0200, 16'h003f));
    send_record(sprite_of(16'h0001, 16'h0000, 16'hffff, 16'h0000, 16'h03ff, 16'h0000));
    end_phase();

    // random records under changing settings and idle patterns
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: write_config(1'b0, 10'd320, 10'd224);
        1: write_config(1'b1, 10'($urandom_range(1023)), 10'($urandom_range(1023)));
        2: write_config(1'b1, 10'd1023, 10'd1);
        3: write_config(1'b0, 10'($urandom_range(1023)), 10'($urandom_range(1023)));
        4: write_config(1'b1, 10'd1, 10'd1023);
        default: write_config(1'b1, 10'($urandom_range(1023)), 10'($urandom_range(1023)));
      endcase
      if (p < 2) begin
        send_idle_pct = 24;
        take_idle_pct = 78;
      end else if (p < 4) begin
        send_idle_pct = 78;
        take_idle_pct = 24;
      end else begin
        send_idle_pct = 0;
        take_idle_pct = 0;
      end
      // long output stall while records keep coming
      if (p == RANDOM_PHASES - 1)
        holdoff_req = 1'b1;
      enabled_target = enabled_sent + PHASE_RECORDS;
      while (enabled_sent < enabled_target)
        send_record(random_sprite());
      end_phase();
    end

    $display("run covered %0d records (%0d enabled) under %0d screen settings",
             records_sent, enabled_sent, settings_used);
    $display("%0d column commands checked, one %0d-cycle output stall with input backed up",
             columns_checked, HOLDOFF_CYCLES);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sprite_record_to_tile_columns_top.f -----
+incdir+rtl
rtl/sprc_pkg.sv
rtl/sprc_front.sv
rtl/sprc_queue.sv
rtl/sprc_back.sv
rtl/sprite_record_to_tile_columns_top.sv
verif/sprite_columns_checker.sv
verif/sprite_record_to_tile_columns_top_tb.sv
